### rtl/irsn_pkg.sv
// Package: shared types, constants and the sine table for the rotate/scale block.
package irsn_pkg;
	localparam int unsigned PIX_W = 16;
	localparam int unsigned ADDR_W = 16;
	localparam int unsigned DIV_STEPS = 17;

	typedef enum logic [2:0] {
		CFG_MODE       = 3'd0,
		CFG_SRC_WIDTH  = 3'd1,
		CFG_SRC_HEIGHT = 3'd2,
		CFG_DST_WIDTH  = 3'd3,
		CFG_DST_HEIGHT = 3'd4,
		CFG_ANGLE      = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_EMIT  = 1'b1
	} action_t;

	typedef struct packed {
		logic           emit;
		logic [7:0]     x;
		logic [7:0]     y;
		logic [7:0]     sx;
		logic [7:0]     sy;
		logic [PIX_W-1:0] pix;
		logic           outside;
		logic           last;
	} job_t;

	function automatic logic [14:0] quarter_sine(input logic [6:0] k);
		logic [14:0] r;
		begin
			unique case (k)
				7'd0: r = 15'd0; 7'd1: r = 15'd286; 7'd2: r = 15'd572; 7'd3: r = 15'd857;
				7'd4: r = 15'd1143; 7'd5: r = 15'd1428; 7'd6: r = 15'd1713; 7'd7: r = 15'd1997;
				7'd8: r = 15'd2280; 7'd9: r = 15'd2563; 7'd10: r = 15'd2845; 7'd11: r = 15'd3126;
				7'd12: r = 15'd3406; 7'd13: r = 15'd3686; 7'd14: r = 15'd3964; 7'd15: r = 15'd4240;
				7'd16: r = 15'd4516; 7'd17: r = 15'd4790; 7'd18: r = 15'd5063; 7'd19: r = 15'd5334;
				7'd20: r = 15'd5604; 7'd21: r = 15'd5872; 7'd22: r = 15'd6138; 7'd23: r = 15'd6402;
				7'd24: r = 15'd6664; 7'd25: r = 15'd6924; 7'd26: r = 15'd7182; 7'd27: r = 15'd7438;
				7'd28: r = 15'd7692; 7'd29: r = 15'd7943; 7'd30: r = 15'd8192; 7'd31: r = 15'd8438;
				7'd32: r = 15'd8682; 7'd33: r = 15'd8923; 7'd34: r = 15'd9162; 7'd35: r = 15'd9397;
				7'd36: r = 15'd9630; 7'd37: r = 15'd9860; 7'd38: r = 15'd10087; 7'd39: r = 15'd10311;
				7'd40: r = 15'd10531; 7'd41: r = 15'd10749; 7'd42: r = 15'd10963; 7'd43: r = 15'd11174;
				7'd44: r = 15'd11381; 7'd45: r = 15'd11585; 7'd46: r = 15'd11786; 7'd47: r = 15'd11982;
				7'd48: r = 15'd12176; 7'd49: r = 15'd12365; 7'd50: r = 15'd12551; 7'd51: r = 15'd12733;
				7'd52: r = 15'd12911; 7'd53: r = 15'd13085; 7'd54: r = 15'd13255; 7'd55: r = 15'd13421;
				7'd56: r = 15'd13583; 7'd57: r = 15'd13741; 7'd58: r = 15'd13894; 7'd59: r = 15'd14044;
				7'd60: r = 15'd14189; 7'd61: r = 15'd14330; 7'd62: r = 15'd14466; 7'd63: r = 15'd14598;
				7'd64: r = 15'd14726; 7'd65: r = 15'd14849; 7'd66: r = 15'd14968; 7'd67: r = 15'd15082;
				7'd68: r = 15'd15191; 7'd69: r = 15'd15296; 7'd70: r = 15'd15396; 7'd71: r = 15'd15491;
				7'd72: r = 15'd15582; 7'd73: r = 15'd15668; 7'd74: r = 15'd15749; 7'd75: r = 15'd15826;
				7'd76: r = 15'd15897; 7'd77: r = 15'd15964; 7'd78: r = 15'd16026; 7'd79: r = 15'd16083;
				7'd80: r = 15'd16135; 7'd81: r = 15'd16182; 7'd82: r = 15'd16225; 7'd83: r = 15'd16262;
				7'd84: r = 15'd16294; 7'd85: r = 15'd16322; 7'd86: r = 15'd16344; 7'd87: r = 15'd16362;
				7'd88: r = 15'd16374; 7'd89: r = 15'd16382; 7'd90: r = 15'd16384;
				default: r = 15'd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic signed [15:0] sine_of(input logic [8:0] deg);
		logic [14:0] m;
		logic neg;
		begin
			if (deg <= 9'd90) begin
				m = quarter_sine(deg[6:0]); neg = 1'b0;
			end else if (deg <= 9'd180) begin
				m = quarter_sine(7'(9'd180 - deg)); neg = 1'b0;
			end else if (deg <= 9'd270) begin
				m = quarter_sine(7'(deg - 9'd180)); neg = 1'b1;
			end else begin
				m = quarter_sine(7'(9'd360 - deg)); neg = 1'b1;
			end
			return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
		end
	endfunction

	function automatic logic [8:0] fit_size(input logic [8:0] v);
		return (v == 9'd0) ? 9'd1 : ((v > 9'd256) ? 9'd256 : v);
	endfunction
endpackage

### rtl/irsn_ram.sv
// Generic single-port-write, registered-read RAM.
module irsn_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

### rtl/irsn_front.sv
// Front: raster sequencing, coordinate mapping with four parallel multipliers and two bit-serial dividers.
module irsn_front import irsn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  wx,
	input  logic [7:0]  wy,
	input  logic [PIX_W-1:0] pix,
	input  logic        mode_q,
	input  logic [8:0]  src_width_q,
	input  logic [8:0]  src_height_q,
	input  logic [8:0]  dst_width_q,
	input  logic [8:0]  dst_height_q,
	input  logic [8:0]  angle_q,
	output logic        job_valid,
	input  logic        job_ready,
	output job_t        job
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_ROT  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [7:0] rx_q, ry_q, x_q, y_q;
	logic [8:0] sw_q, sh_q, dw_q, dh_q;
	logic signed [15:0] s_q, c_q;
	logic signed [24:0] p0_q, p1_q, p2_q, p3_q;
	logic [16:0] numx_q, numy_q, remx_q, remy_q;
	logic [4:0] cnt_q;
	job_t job_q;
	logic       last_q;

	logic [8:0] sw, sh, dw, dh, ang;
	logic [7:0] cx, cy;
	logic signed [25:0] vx, vy;
	logic signed [17:0] tx, ty;
	logic [17:0] rxs, rys;
	logic [16:0] bx, by;
	logic        rot_out;

	assign sw = fit_size(src_width_q);
	assign sh = fit_size(src_height_q);
	assign dw = fit_size(dst_width_q);
	assign dh = fit_size(dst_height_q);
	assign ang = (angle_q >= 9'd360) ? 9'(angle_q - 9'd360) : angle_q;
	assign cx = ({1'b0, rx_q} >= dw || {1'b0, ry_q} >= dh) ? 8'd0 : rx_q;
	assign cy = ({1'b0, rx_q} >= dw || {1'b0, ry_q} >= dh) ? 8'd0 : ry_q;

	assign vx = 26'(p0_q) - 26'(p1_q);
	assign vy = 26'(p2_q) + 26'(p3_q);
	assign tx = vx[25] ? -18'((-vx) >>> 14) : 18'(vx >>> 14);
	assign ty = vy[25] ? -18'((-vy) >>> 14) : 18'(vy >>> 14);
	assign rot_out = tx < 18'sd0 || ty < 18'sd0 || tx >= $signed({9'd0, sw_q})
		|| ty >= $signed({9'd0, sh_q});

	assign rxs = {remx_q, numx_q[16]} - {9'd0, dw_q};
	assign rys = {remy_q, numy_q[16]} - {9'd0, dh_q};
	assign bx = rxs[17] ? {remx_q[15:0], numx_q[16]} : rxs[16:0];
	assign by = rys[17] ? {remy_q[15:0], numy_q[16]} : rys[16:0];

	assign in_ready = (state_q == ST_IDLE);
	assign job_valid = (state_q == ST_OUT);
	assign job = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rx_q <= 8'd0;
			ry_q <= 8'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (action == ACT_EMIT) begin
							x_q <= cx;
							y_q <= cy;
							sw_q <= sw;
							sh_q <= sh;
							dw_q <= dw;
							dh_q <= dh;
							s_q <= sine_of(ang);
							c_q <= sine_of((ang >= 9'd270) ? 9'(ang - 9'd270) : 9'(ang + 9'd90));
							last_q <= ({1'b0, cx} + 9'd1 == dw) && ({1'b0, cy} + 9'd1 == dh);
							if ({1'b0, cx} + 9'd1 >= dw) begin
								rx_q <= 8'd0;
								ry_q <= ({1'b0, cy} + 9'd1 >= dh) ? 8'd0 : 8'(cy + 8'd1);
							end else begin
								rx_q <= 8'(cx + 8'd1);
								ry_q <= cy;
							end
							state_q <= mode_q ? ST_DIV : ST_MUL;
							numx_q <= {9'd0, cx} * {8'd0, sw};
							numy_q <= {9'd0, cy} * {8'd0, sh};
							remx_q <= 17'd0;
							remy_q <= 17'd0;
							cnt_q <= 5'd0;
						end else begin
							job_q.emit <= 1'b0;
							job_q.x <= wx;
							job_q.y <= wy;
							job_q.sx <= 8'd0;
							job_q.sy <= 8'd0;
							job_q.pix <= pix;
							job_q.outside <= 1'b0;
							job_q.last <= 1'b0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_MUL: begin
					p0_q <= $signed({1'b0, x_q}) * c_q;
					p1_q <= $signed({1'b0, y_q}) * s_q;
					p2_q <= $signed({1'b0, x_q}) * s_q;
					p3_q <= $signed({1'b0, y_q}) * c_q;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					job_q.emit <= 1'b1;
					job_q.x <= x_q;
					job_q.y <= y_q;
					job_q.sx <= rot_out ? 8'd0 : tx[7:0];
					job_q.sy <= rot_out ? 8'd0 : ty[7:0];
					job_q.pix <= {PIX_W{1'b0}};
					job_q.outside <= rot_out;
					job_q.last <= last_q;
					state_q <= ST_OUT;
				end
				ST_DIV: begin
					remx_q <= bx;
					remy_q <= by;
					numx_q <= {numx_q[15:0], ~rxs[17]};
					numy_q <= {numy_q[15:0], ~rys[17]};
					cnt_q <= 5'(cnt_q + 5'd1);
					if (cnt_q == 5'(DIV_STEPS - 1)) begin
						job_q.emit <= 1'b1;
						job_q.x <= x_q;
						job_q.y <= y_q;
						job_q.sx <= {numx_q[6:0], ~rxs[17]};
						job_q.sy <= {numy_q[6:0], ~rys[17]};
						job_q.pix <= {PIX_W{1'b0}};
						job_q.outside <= 1'b0;
						job_q.last <= last_q;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (job_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/irsn_back.sv
// Back: frame store writes and reads, output register.
module irsn_back import irsn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_ready,
	input  job_t        job,
	output logic        m_valid,
	input  logic        m_ready,
	output logic [PIX_W-1:0] pixel_out,
	output logic [7:0]  dst_x,
	output logic [7:0]  dst_y,
	output logic        outside,
	output logic        last
);
	logic rd_s1;
	logic [PIX_W-1:0] rdata;
	logic out_s1, last_s1;
	logic [7:0] x_s1, y_s1;
	logic wr_go, rd_go;

	assign job_ready = job.emit ? (!rd_s1 && !m_valid) : 1'b1;
	assign wr_go = job_valid && job_ready && !job.emit;
	assign rd_go = job_valid && job_ready && job.emit;

	irsn_ram #(.WIDTH(PIX_W), .DEPTH(1 << ADDR_W)) u_ram (
		.clk(clk),
		.we(wr_go),
		.waddr({job.y, job.x}),
		.wdata(job.pix),
		.re(rd_go),
		.raddr({job.sy, job.sx}),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			m_valid <= 1'b0;
		end else begin
			rd_s1 <= rd_go;
			if (rd_go) begin
				out_s1 <= job.outside;
				last_s1 <= job.last;
				x_s1 <= job.x;
				y_s1 <= job.y;
			end
			if (rd_s1) begin
				m_valid <= 1'b1;
				pixel_out <= out_s1 ? {PIX_W{1'b0}} : rdata;
				outside <= out_s1;
				last <= last_s1;
				dst_x <= x_s1;
				dst_y <= y_s1;
			end else if (m_valid && m_ready) begin
				m_valid <= 1'b0;
			end
		end
	end
endmodule

### rtl/image_rotate_scale_nearest.sv
// Top level: nearest-neighbour rotate/scale with on-chip frame store.
// Write beat: no new beat is accepted until the write has left the front; writes never wait on the output register.
// Emit beat, rotate: accept, multiply, map, queue (may wait on the output register), store read, then m_tvalid.
// Emit beat, scale: accept, the 17-step divider, queue (may wait on the output register), store read, then m_tvalid.
// One beat in the front at a time: a new emit is accepted only after the previous one has left the front.
// Reset clears raster position and registers (mode 0, sizes 256, angle 0); store kept.
module image_rotate_scale_nearest import irsn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // src_x[7:0], src_y[15:8], pixel_in[31:16]
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // pixel_out[15:0], dst_x[23:16], dst_y[31:24]
	output logic        m_tuser,   // outside
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	logic mode_q;
	logic [8:0] src_width_q, src_height_q, dst_width_q, dst_height_q, angle_q;
	logic job_valid, job_ready;
	job_t job;
	logic [PIX_W-1:0] pixel_out;
	logic [7:0] dst_x, dst_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			src_width_q <= 9'd256;
			src_height_q <= 9'd256;
			dst_width_q <= 9'd256;
			dst_height_q <= 9'd256;
			angle_q <= 9'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MODE:       mode_q <= cfg_data[0];
				CFG_SRC_WIDTH:  src_width_q <= cfg_data;
				CFG_SRC_HEIGHT: src_height_q <= cfg_data;
				CFG_DST_WIDTH:  dst_width_q <= cfg_data;
				CFG_DST_HEIGHT: dst_height_q <= cfg_data;
				CFG_ANGLE:      angle_q <= cfg_data;
				default: ;
			endcase
		end
	end

	irsn_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.action(s_tuser), .wx(s_tdata[7:0]), .wy(s_tdata[15:8]), .pix(s_tdata[31:16]),
		.mode_q(mode_q), .src_width_q(src_width_q), .src_height_q(src_height_q),
		.dst_width_q(dst_width_q), .dst_height_q(dst_height_q), .angle_q(angle_q),
		.job_valid(job_valid), .job_ready(job_ready), .job(job)
	);

	irsn_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_ready(job_ready), .job(job),
		.m_valid(m_tvalid), .m_ready(m_tready),
		.pixel_out(pixel_out), .dst_x(dst_x), .dst_y(dst_y),
		.outside(m_tuser), .last(m_tlast)
	);

	assign m_tdata = {dst_y, dst_x, pixel_out};
endmodule
